>>> hdl/otpm_pkg.sv
// Package for the online truncated polynomial multiplier.
// Holds coefficient widths, the sequencer state type and the small control structs.
// No dependencies.
package otpm_pkg;

	localparam int COEF_W    = 31;
	localparam int PROD_W    = 2 * COEF_W;
	localparam int IDX_OUT_W = 10;

	localparam logic [COEF_W-1:0] MOD_RESET = 31'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] MOD_MIN   = 31'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED_F,
		S_RED_G,
		S_MAC,
		S_RED_SUM,
		S_EMIT
	} otpm_state_t;

	// Write enables for the two coefficient memories.
	typedef struct packed {
		logic f;
		logic g;
	} otpm_wen_t;

	// Status of the serial remainder unit.
	typedef struct packed {
		logic busy;
		logic done;
	} otpm_red_stat_t;

endpackage

>>> hdl/otpm_reduce.sv
// Bit-serial remainder unit: reduces a left-aligned value modulo a 31-bit modulus.
// One quotient bit per cycle. Depends on otpm_pkg.
module otpm_reduce #(
	parameter int VAL_W = 72,
	parameter int STEP_W = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VAL_W-1:0]             value,
	input  logic [STEP_W-1:0]            steps,
	input  logic [otpm_pkg::COEF_W-1:0]  modulus,
	output otpm_pkg::otpm_red_stat_t     stat,
	output logic [otpm_pkg::COEF_W-1:0]  rem
);
	import otpm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VAL_W-1:0]  sh_q;
	logic [COEF_W-1:0] rem_q;

	logic [COEF_W:0]   trial;
	logic [COEF_W:0]   diff;
	logic [COEF_W-1:0] rem_next;

	// Shift in the next bit; the partial remainder stays below the modulus,
	// so one compare and subtract is enough.
	assign trial    = {rem_q, sh_q[VAL_W-1]};
	assign diff     = trial - {1'b0, modulus};
	assign rem_next = (trial >= {1'b0, modulus}) ? diff[COEF_W-1:0] : trial[COEF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 1;
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

>>> hdl/otpm_store.sv
// Coefficient memories for the two input polynomials.
// One write port shared by both, one registered read port each. Depends on otpm_pkg.
module otpm_store #(
	parameter int DEPTH = 1024,
	parameter int IW = 10
) (
	input  logic                         clk,
	input  otpm_pkg::otpm_wen_t          wen,
	input  logic [IW-1:0]                waddr,
	input  logic [otpm_pkg::COEF_W-1:0]  wdata,
	input  logic [IW-1:0]                raddr_f,
	input  logic [IW-1:0]                raddr_g,
	output logic [otpm_pkg::COEF_W-1:0]  rdata_f,
	output logic [otpm_pkg::COEF_W-1:0]  rdata_g
);
	import otpm_pkg::*;

	logic [COEF_W-1:0] f_mem [DEPTH];
	logic [COEF_W-1:0] g_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen.f) begin
			f_mem[waddr] <= wdata;
		end
		rdata_f <= f_mem[raddr_f];
	end

	always_ff @(posedge clk) begin
		if (wen.g) begin
			g_mem[waddr] <= wdata;
		end
		rdata_g <= g_mem[raddr_g];
	end

endmodule

>>> hdl/otpm_mac.sv
// Convolution engine: walks j = 0..i over the memories and sums f[j]*g[i-j].
// Read, multiply and accumulate stages. Depends on otpm_pkg.
module otpm_mac #(
	parameter int IW = 10,
	parameter int ACC_W = 72
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [IW-1:0]                last_idx,
	output logic [IW-1:0]                raddr_f,
	output logic [IW-1:0]                raddr_g,
	input  logic [otpm_pkg::COEF_W-1:0]  rdata_f,
	input  logic [otpm_pkg::COEF_W-1:0]  rdata_g,
	output logic                         done,
	output logic [ACC_W-1:0]             acc
);
	import otpm_pkg::*;

	logic              run_q;
	logic [IW-1:0]     j_q;
	logic [IW-1:0]     last_q;
	logic              vld_s1;
	logic              last_s1;
	logic              vld_s2;
	logic              last_s2;
	logic              done_q;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]  acc_q;

	logic at_end;

	assign at_end  = (j_q == last_q);
	assign raddr_f = j_q;
	assign raddr_g = last_q - j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			j_q     <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				j_q   <= '0;
			end else if (run_q) begin
				if (at_end) begin
					run_q <= 1'b0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			vld_s1  <= run_q && !start;
			last_s1 <= run_q && !start && at_end;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			done_q  <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_q <= last_idx;
		end
		prod_s2 <= PROD_W'(rdata_f) * PROD_W'(rdata_g);
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

>>> hdl/online_truncated_poly_multiply_mod.sv
// Top level of the online truncated polynomial multiplier modulo m.
// Depends on otpm_pkg, otpm_reduce, otpm_store and otpm_mac.
//
// Usage: each transfer on the input channel (in_valid/in_ready) brings the next
// coefficient pair f[i], g[i]; start_series marks coefficient 0 of a new series.
// For every input transfer exactly one result leaves on the output channel
// (out_valid/out_ready): product_coef = h[i] mod m, coef_index = i, overflow.
// Once MAX_LEN coefficients of a series are stored, further pairs are dropped
// and answered with overflow set, a zero coefficient and index zero.
// The modulus register is to be written through cfg_we/cfg_data only while the
// block is idle; the block does not enforce this. Values below 2 act as 2.
// Timing: one item at a time. Coefficient i goes through two serial reductions
// of the incoming pair, i+1 memory reads through the multiply-accumulate
// pipeline, and a serial reduction of the wide sum. An overflow item skips
// these steps and goes straight to the output register.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, a finished item waits for the register to free up.
// Reset clears the index counter, empties the output register and restores the
// modulus to 2^31-1. The memories need no clearing: only entries written in the
// current series are ever read.
module online_truncated_poly_multiply_mod #(
	parameter int MAX_LEN = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [otpm_pkg::COEF_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         start_series,
	input  logic [otpm_pkg::COEF_W-1:0]  f_coef,
	input  logic [otpm_pkg::COEF_W-1:0]  g_coef,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [otpm_pkg::COEF_W-1:0]  product_coef,
	output logic [otpm_pkg::IDX_OUT_W-1:0] coef_index,
	output logic                         overflow
);
	import otpm_pkg::*;

	localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW     = $clog2(MAX_LEN + 1);
	localparam int ACC_W  = PROD_W + IW;
	localparam int STEP_W = $clog2(ACC_W + 1);

	otpm_state_t state_q, state_d;

	logic [COEF_W-1:0]    modulus_q;
	logic [COEF_W-1:0]    m_eff;
	logic [CW-1:0]        next_index_q;
	logic [CW-1:0]        idx_sel;
	logic                 idx_ovf;
	logic                 accept;

	logic [COEF_W-1:0]    g_q;
	logic [IW-1:0]        cur_idx_q;
	logic                 ovf_q;

	logic                 out_valid_q;
	logic [COEF_W-1:0]    product_q;
	logic [IDX_OUT_W-1:0] coef_index_q;
	logic                 overflow_q;

	// Sequencer outputs.
	logic                 red_start;
	logic [ACC_W-1:0]     red_value;
	logic [STEP_W-1:0]    red_steps;
	otpm_wen_t            wen;
	logic                 mac_start;
	logic                 out_load;

	otpm_red_stat_t       red_stat;
	logic [COEF_W-1:0]    red_rem;
	logic [IW-1:0]        raddr_f;
	logic [IW-1:0]        raddr_g;
	logic [COEF_W-1:0]    rdata_f;
	logic [COEF_W-1:0]    rdata_g;
	logic                 mac_done;
	logic [ACC_W-1:0]     mac_acc;

	assign m_eff   = (modulus_q < MOD_MIN) ? MOD_MIN : modulus_q;
	assign accept  = in_valid && in_ready;
	assign idx_sel = start_series ? '0 : next_index_q;
	// The counter never passes MAX_LEN, so equality marks a full store.
	assign idx_ovf = (idx_sel == CW'(MAX_LEN));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = idx_ovf ? S_EMIT : S_RED_F;
				end
			end
			S_RED_F: begin
				if (red_stat.done) begin
					state_d = S_RED_G;
				end
			end
			S_RED_G: begin
				if (red_stat.done) begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				if (mac_done) begin
					state_d = S_RED_SUM;
				end
			end
			S_RED_SUM: begin
				if (red_stat.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs. The reducer is restarted in the same cycle it reports
	// done, so the entering pair is reduced back to back.
	always_comb begin
		in_ready  = 1'b0;
		red_start = 1'b0;
		red_value = ACC_W'(f_coef) << (ACC_W - COEF_W);
		red_steps = STEP_W'(COEF_W);
		wen       = '0;
		mac_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				red_start = in_valid && !idx_ovf;
			end
			S_RED_F: begin
				red_value = ACC_W'(g_q) << (ACC_W - COEF_W);
				if (red_stat.done) begin
					wen.f     = 1'b1;
					red_start = 1'b1;
				end
			end
			S_RED_G: begin
				if (red_stat.done) begin
					wen.g     = 1'b1;
					mac_start = 1'b1;
				end
			end
			S_MAC: begin
				red_value = mac_acc;
				red_steps = STEP_W'(ACC_W);
				red_start = mac_done;
			end
			S_RED_SUM: begin
			end
			S_EMIT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			modulus_q    <= MOD_RESET;
			next_index_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				modulus_q <= cfg_data;
			end
			if (accept && !idx_ovf) begin
				next_index_q <= idx_sel + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			g_q       <= g_coef;
			cur_idx_q <= IW'(idx_sel);
			ovf_q     <= idx_ovf;
		end
		if (out_load) begin
			product_q    <= ovf_q ? '0 : red_rem;
			coef_index_q <= ovf_q ? '0 : IDX_OUT_W'(cur_idx_q);
			overflow_q   <= ovf_q;
		end
	end

	otpm_reduce #(
		.VAL_W (ACC_W),
		.STEP_W(STEP_W)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.value  (red_value),
		.steps  (red_steps),
		.modulus(m_eff),
		.stat   (red_stat),
		.rem    (red_rem)
	);

	otpm_store #(
		.DEPTH(MAX_LEN),
		.IW   (IW)
	) u_store (
		.clk    (clk),
		.wen    (wen),
		.waddr  (cur_idx_q),
		.wdata  (red_rem),
		.raddr_f(raddr_f),
		.raddr_g(raddr_g),
		.rdata_f(rdata_f),
		.rdata_g(rdata_g)
	);

	otpm_mac #(
		.IW   (IW),
		.ACC_W(ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.last_idx(cur_idx_q),
		.raddr_f (raddr_f),
		.raddr_g (raddr_g),
		.rdata_f (rdata_f),
		.rdata_g (rdata_g),
		.done    (mac_done),
		.acc     (mac_acc)
	);

	assign out_valid    = out_valid_q;
	assign product_coef = product_q;
	assign coef_index   = coef_index_q;
	assign overflow     = overflow_q;

`ifndef SYNTH
	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.done |-> (red_rem < m_eff))
		else $error("remainder not below modulus");

	a_mac_after_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		mac_start |=> !red_stat.busy)
		else $error("convolution started while reducer busy");

	a_index_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		next_index_q <= CW'(MAX_LEN))
		else $error("coefficient index ran past store depth");

	a_stored_item_reduces: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !idx_ovf) |=> (state_q == S_RED_F) && red_stat.busy)
		else $error("accepted pair not sent to reducer");
`endif

endmodule

>>> sim/online_truncated_poly_multiply_mod_tb.sv
// Self-checking testbench for online_truncated_poly_multiply_mod.
// Holds a scoreboard class that predicts each product coefficient, plus plain driver tasks.
// Depends on otpm_pkg and the online_truncated_poly_multiply_mod RTL.
`timescale 1ns / 100ps

module online_truncated_poly_multiply_mod_tb;
	import otpm_pkg::*;

	localparam int MAX_LEN        = 1024;
	localparam int RANDOM_PAIRS   = 560;
	localparam int QUIET_PAIRS    = 60;
	localparam int MAX_REPORTS    = 10;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 300;
	// The slowest transfer-free stretch is a coefficient near the store depth plus
	// a full receiver stall; this allows several times that.
	localparam int WATCHDOG_LIMIT = 10000;

	localparam logic [COEF_W-1:0] ALL_ONES = '1;
	localparam logic [COEF_W-1:0] TOP_COEF = MOD_RESET - COEF_W'(1);

	// One expected output transfer.
	typedef struct {
		logic [COEF_W-1:0]    coef;
		logic [IDX_OUT_W-1:0] idx;
		logic                 ovf;
	} coef_result_t;

	// Tracks the coefficient stores, the series index and the modulus, and
	// predicts h[i] for every accepted pair. Results are matched in order.
	class truncated_product_checker;
		logic [COEF_W-1:0] modulus;
		logic [COEF_W-1:0] f_seen [MAX_LEN];
		logic [COEF_W-1:0] g_seen [MAX_LEN];
		int unsigned       next_idx;
		coef_result_t      pending_coefs [$];
		int unsigned       mismatches;
		int unsigned       coefs_checked;
		int unsigned       overflows_checked;

		function new();
			modulus = MOD_RESET;
			next_idx = 0;
			mismatches = 0;
			coefs_checked = 0;
			overflows_checked = 0;
		endfunction

		function logic [COEF_W-1:0] effective_mod();
			return (modulus < MOD_MIN) ? MOD_MIN : modulus;
		endfunction

		function int unsigned pending();
			return pending_coefs.size();
		endfunction

		// Called once per accepted input transfer.
		function void take_pair(logic new_series, logic [COEF_W-1:0] f,
				logic [COEF_W-1:0] g);
			bit [63:0]    m;
			bit [63:0]    acc;
			bit [63:0]    term;
			int unsigned  j;
			coef_result_t r;
			m = 64'(effective_mod());
			if (new_series)
				next_idx = 0;
			if (next_idx >= MAX_LEN) begin
				// Past the store depth the pair is dropped and flagged.
				next_idx = MAX_LEN;
				r.coef = '0;
				r.idx = '0;
				r.ovf = 1'b1;
			end else begin
				f_seen[next_idx] = COEF_W'(64'(f) % m);
				g_seen[next_idx] = COEF_W'(64'(g) % m);
				acc = 0;
				for (j = 0; j <= next_idx; j++) begin
					term = 64'(f_seen[j]);
					acc += (term * 64'(g_seen[next_idx - j])) % m;
				end
				r.coef = COEF_W'(acc % m);
				r.idx = next_idx[IDX_OUT_W-1:0];
				r.ovf = 1'b0;
				next_idx++;
			end
			pending_coefs.insert(pending_coefs.size(), r);
		endfunction

		// Called once per accepted output transfer.
		function void check_coef(logic [COEF_W-1:0] coef, logic [IDX_OUT_W-1:0] idx,
				logic ovf);
			coef_result_t want;
			if (pending_coefs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result: coef=%0d index=%0d overflow=%0b",
						$realtime, coef, idx, ovf);
				return;
			end
			want = pending_coefs.pop_front();
			coefs_checked++;
			if (want.ovf)
				overflows_checked++;
			if (coef !== want.coef || idx !== want.idx || ovf !== want.ovf) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: mismatch: exp coef=%0d idx=%0d ovf=%0b, got %0d %0d %0b",
						$realtime, want.coef, want.idx, want.ovf, coef, idx, ovf);
			end
		endfunction
	endclass

	// Every block input starts at a known value.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [COEF_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 start_series = 1'b0;
	logic [COEF_W-1:0]    f_coef = '0;
	logic [COEF_W-1:0]    g_coef = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COEF_W-1:0]    product_coef;
	logic [IDX_OUT_W-1:0] coef_index;
	logic                 overflow;

	// Idling on either side can be switched off for the closing stretch.
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	int unsigned pairs_sent = 0;
	int unsigned modulus_writes = 0;

	truncated_product_checker product_chk;

	online_truncated_poly_multiply_mod #(
		.MAX_LEN(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_series(start_series),
		.f_coef(f_coef),
		.g_coef(g_coef),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.product_coef(product_coef),
		.coef_index(coef_index),
		.overflow(overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: ready most of the time, with random stall bursts. Only one
	// assignment to out_ready is made per clock edge.
	always begin
		@(posedge clk);
		if (stalls_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	// Output transfers are checked on the edge that completes them. Values read
	// right after the edge are the ones the block saw, since every input is
	// driven with nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			product_chk.check_coef(product_coef, coef_index, overflow);
	end

	// Ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timed out after %0d cycles without a transfer", WATCHDOG_LIMIT);
		$display("online_truncated_poly_multiply_mod verification failed");
		$finish;
	end

	// Offers one coefficient pair, possibly after an idle burst, and returns on
	// the edge where it is accepted. in_valid stays high afterwards so that
	// back-to-back pairs need no gap; pause_until_drained lowers it.
	task automatic send_pair(input logic new_series, input logic [COEF_W-1:0] f,
			input logic [COEF_W-1:0] g);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_series <= new_series;
		f_coef <= f;
		g_coef <= g;
		do @(posedge clk); while (!in_ready);
		product_chk.take_pair(new_series, f, g);
		pairs_sent++;
	endtask

	// Stops offering pairs and waits until every pending coefficient is out.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (product_chk.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Single-cycle register write; only called while the block is idle.
	task automatic write_modulus(input logic [COEF_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		product_chk.modulus = value;
		modulus_writes++;
	endtask

	// Coefficients lean toward the interesting values around zero, the
	// current modulus and the all-ones pattern, with plain random values mixed in.
	function automatic logic [COEF_W-1:0] pick_coef();
		logic [COEF_W-1:0] m;
		m = product_chk.effective_mod();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			2: return m - COEF_W'(1);
			3: return m;
			4: return COEF_W'($urandom_range(0, 15));
			default: return COEF_W'($urandom());
		endcase
	endfunction

	// Moduli cover the values below 2, the smallest legal one, the largest,
	// and small, medium and full-range random values.
	function automatic logic [COEF_W-1:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COEF_W'(1);
			2: return MOD_MIN;
			3: return MOD_RESET;
			4: return TOP_COEF;
			5: return COEF_W'($urandom_range(3, 255));
			6: return COEF_W'($urandom_range(256, 65535));
			default: return COEF_W'($urandom_range(2, MOD_RESET));
		endcase
	endfunction

	initial begin : stimulus
		int unsigned random_pairs;
		int unsigned series_len;
		int unsigned k;
		bit          keep_series;

		product_chk = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset modulus 2^31-1. The very first pair carries no
		// start flag and must still count as coefficient 0. The all-ones input
		// equals the modulus and reduces to zero; m-1 squared is the largest product.
		send_pair(1'b0, ALL_ONES, ALL_ONES);
		send_pair(1'b0, TOP_COEF, TOP_COEF);
		send_pair(1'b0, '0, TOP_COEF);
		send_pair(1'b0, 31'h2AAA_AAAA, 31'h5555_5555);
		send_pair(1'b0, TOP_COEF, 31'd1);
		// A start restarts the index, twice in a row as well.
		send_pair(1'b1, 31'd1, TOP_COEF);
		send_pair(1'b1, 31'd12345, 31'd67890);
		send_pair(1'b0, ALL_ONES, '0);
		pause_until_drained();

		// Register values 0 and 1 behave as modulus 2. The series keeps running
		// across the change, so stored coefficients keep their old reduction.
		write_modulus('0);
		send_pair(1'b0, 31'd3, 31'd5);
		send_pair(1'b1, ALL_ONES, ALL_ONES);
		send_pair(1'b0, 31'd1, 31'd1);
		pause_until_drained();
		write_modulus(31'd1);
		send_pair(1'b0, TOP_COEF, 31'd7);
		send_pair(1'b0, 31'd2, 31'd3);
		pause_until_drained();
		write_modulus(MOD_MIN);
		send_pair(1'b1, ALL_ONES, 31'd1);
		send_pair(1'b0, 31'd1, 31'd1);
		send_pair(1'b0, 31'd1, 31'd1);
		pause_until_drained();
		write_modulus(31'd3);
		send_pair(1'b0, ALL_ONES, TOP_COEF);
		pause_until_drained();
		write_modulus(MOD_RESET);
		send_pair(1'b0, TOP_COEF, TOP_COEF);
		send_pair(1'b1, '0, '0);
		pause_until_drained();

		// Random part: mostly short well-formed series with random content, a
		// few longer ones, and now and then a series that carries on without a
		// start flag, sometimes across a modulus change.
		random_pairs = 0;
		while (random_pairs < RANDOM_PAIRS) begin
			if (random_pairs + QUIET_PAIRS >= RANDOM_PAIRS) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				pause_until_drained();
				if ($urandom_range(0, 1) == 1)
					write_modulus(pick_modulus());
			end
			series_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
				: $urandom_range(1, 24);
			if (series_len > RANDOM_PAIRS - random_pairs)
				series_len = RANDOM_PAIRS - random_pairs;
			keep_series = ($urandom_range(0, 5) == 0);
			for (k = 0; k < series_len; k++)
				send_pair(k == 0 && !keep_series, pick_coef(), pick_coef());
			random_pairs += series_len;
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d coefficient pairs under %0d modulus settings;",
			pairs_sent, modulus_writes);
		$display("checked %0d coefficients, %0d past the store depth, %0d mismatches.",
			product_chk.coefs_checked, product_chk.overflows_checked,
			product_chk.mismatches);
		if (product_chk.mismatches == 0 && product_chk.pending() == 0)
			$display("online_truncated_poly_multiply_mod verification clean");
		else
			$display("online_truncated_poly_multiply_mod verification failed");
		$finish;
	end

endmodule
